// ----- rtl/bfp_pkg.sv -----
`timescale 1ns / 1ps

package bfp_pkg;

  // Payload widths of the command and result channels.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PosW    = 15;
  localparam int unsigned CntW    = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned NextW   = 16;
  localparam int unsigned StatusW = 2;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_FIELD_RD = 2'd0,
    CMD_FIELD_WR = 2'd1,
    CMD_BYTE_WR  = 2'd2,
    CMD_BYTE_RD  = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_PREFIX  = 2'd2
  } status_e;

  // One byte step: what the sequencer hands to the byte unit.
  typedef struct packed {
    logic [7:0]        rdata;  // byte as read from the buffer
    logic              first;  // first byte of the field
    logic [2:0]        lead;   // bits before the field in the first byte
    logic [CntW-1:0]   rem;    // field bits not yet handled
    logic [ValueW-1:0] acc;    // value gathered so far
    logic [ValueW-1:0] kmask;  // mask of the value part of the field
    logic [ValueW-1:0] wv;     // value to store, already masked
  } byte_req_t;

  // Outcome of one byte step.
  typedef struct packed {
    logic [7:0]        wbyte;  // byte to write back
    logic [ValueW-1:0] acc;    // value gathered including this byte
    logic              dirty;  // a prefix bit was set in this byte
    logic [CntW-1:0]   rem;    // field bits left after this byte
  } byte_res_t;

endpackage

// ----- rtl/bfp_stream_if.sv -----
`timescale 1ns / 1ps

// Command channel.
interface bfp_in_if import bfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [PosW-1:0]   bit_position;
  logic [CntW-1:0]   bit_count;
  logic [ValueW-1:0] write_value;

  modport source (output valid, command, bit_position, bit_count, write_value, input ready);
  modport sink   (input valid, command, bit_position, bit_count, write_value, output ready);
endinterface

// Result channel.
interface bfp_out_if import bfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  read_value;
  logic [NextW-1:0]   next_position;
  logic [StatusW-1:0] status;

  modport source (output valid, read_value, next_position, status, input ready);
  modport sink   (input valid, read_value, next_position, status, output ready);
endinterface

// ----- rtl/bit_field_pack_unpack_core.sv -----
`timescale 1ns / 1ps

// Big-endian bit-field insert and extract over an internal byte buffer. Bit 0
// of the buffer is the most significant bit of byte 0. A field command passes
// in order through the first buffer read, the byte loop over the bytes that it
// touches, the load of the result register and the load of the output register
// that offers the result; that last load waits while the result channel still
// holds an earlier result. The pace is set by the single buffer read port,
// which delivers one byte per cycle through a registered read, and by the
// shared byte unit that merges or extracts that byte. Refused and zero-width
// commands skip the buffer read and the byte loop. The block takes a new
// command only while the sequencer is idle, but a finished result may still be
// waiting on the result channel meanwhile. The buffer is not cleared at reset:
// read only bytes that have been written.
module bit_field_pack_unpack_core import bfp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES   = 4096,
  parameter int unsigned WORD_BITS      = 64,
  parameter int unsigned MAX_FIELD_BITS = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfp_in_if.sink    in_i,
  bfp_out_if.source out_o
);

  localparam int unsigned AddrW     = $clog2(BUFFER_BYTES);
  localparam int unsigned TotalBits = BUFFER_BYTES * 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [AddrW-1:0]   ia_q, wa_q;
  logic               sv_q, first_q, wr_q, dirty_q;
  logic [2:0]         lead_q;
  logic [CntW-1:0]    rem_q;
  logic [ValueW-1:0]  acc_q, wv_q, km_q;
  logic [7:0]         rdata_q;
  logic [7:0]         mem_q [BUFFER_BYTES];
  logic [ValueW-1:0]  res_rv_q;
  logic [NextW-1:0]   res_next_q, end_q;
  logic [StatusW-1:0] res_st_q;
  logic               out_valid_q;
  logic [ValueW-1:0]  out_rv_q;
  logic [NextW-1:0]   out_next_q;
  logic [StatusW-1:0] out_st_q;

  logic              accept;
  logic              host;
  logic              is_wr;
  logic [PosW-1:0]   epos;
  logic [CntW-1:0]   ecnt;
  logic [NextW-1:0]  eend;
  logic              refuse;
  logic [CntW-1:0]   k_cnt;
  logic [ValueW-1:0] kmask;
  logic              step;
  logic              last_step;
  logic              out_free;
  byte_req_t         breq;
  byte_res_t         bres;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign step     = (state_q == S_RUN) && sv_q;
  assign last_step = step && (bres.rem == '0);
  assign out_free = !out_valid_q || out_o.ready;

  // Command decode: host byte commands become aligned eight-bit fields.
  always_comb begin
    host   = (in_i.command == CMD_BYTE_WR) || (in_i.command == CMD_BYTE_RD);
    is_wr  = (in_i.command == CMD_FIELD_WR) || (in_i.command == CMD_BYTE_WR);
    epos   = host ? {in_i.bit_position[PosW-1:3], 3'd0} : in_i.bit_position;
    ecnt   = host ? CntW'(8) : in_i.bit_count;
    eend   = {1'b0, epos} + NextW'(ecnt);
    refuse = (32'(ecnt) > MAX_FIELD_BITS) || (32'(eend) > TotalBits);
    k_cnt  = (32'(ecnt) > WORD_BITS) ? CntW'(WORD_BITS) : ecnt;
    kmask  = (k_cnt >= CntW'(ValueW)) ? '1 : ((ValueW'(1) << k_cnt) - ValueW'(1));
  end

  // Shared byte unit.
  always_comb begin
    breq.rdata = rdata_q;
    breq.first = first_q;
    breq.lead  = lead_q;
    breq.rem   = rem_q;
    breq.acc   = acc_q;
    breq.kmask = km_q;
    breq.wv    = wv_q;
  end

  bfp_byte_unit u_byte_unit (
    .req_i (breq),
    .res_o (bres)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (refuse || ecnt == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sv_q <= 1'b0;
      end else if (state_q == S_RUN) begin
        sv_q <= 1'b1;
      end
    end
  end

  // Field context and byte-loop datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ia_q    <= AddrW'(epos >> 3);
      lead_q  <= epos[2:0];
      rem_q   <= ecnt;
      acc_q   <= '0;
      dirty_q <= 1'b0;
      first_q <= 1'b1;
      wr_q    <= is_wr;
      km_q    <= kmask;
      wv_q    <= in_i.write_value & kmask;
      end_q   <= eend;
      res_rv_q   <= '0;
      res_next_q <= {1'b0, in_i.bit_position};
      res_st_q   <= refuse ? ST_REFUSED : ST_OK;
    end else if (state_q == S_RUN) begin
      ia_q <= ia_q + AddrW'(1);
      wa_q <= ia_q;
      if (step) begin
        rem_q   <= bres.rem;
        acc_q   <= bres.acc;
        dirty_q <= dirty_q | bres.dirty;
        first_q <= 1'b0;
      end
      if (last_step) begin
        res_rv_q   <= wr_q ? '0 : bres.acc;
        res_next_q <= end_q;
        res_st_q   <= (!wr_q && (dirty_q || bres.dirty)) ? ST_PREFIX : ST_OK;
      end
    end
  end

  // Byte buffer: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[ia_q];
    if (step && wr_q) begin
      mem_q[wa_q] <= bres.wbyte;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_rv_q   <= res_rv_q;
      out_next_q <= res_next_q;
      out_st_q   <= res_st_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_value    = out_rv_q;
  assign out_o.next_position = out_next_q;
  assign out_o.status        = out_st_q;

  // A byte step only runs while field bits remain.
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> rem_q != '0)
    else $error("byte step with no field bits left");

  // A refused command never returns data.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_REFUSED |-> out_o.read_value == '0)
    else $error("refused command returned data");

  // A write command never reports a dirty prefix.
  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step && wr_q |=> res_st_q == ST_OK)
    else $error("write reported a prefix status");

  // A command transfer always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after a command transfer");

endmodule

// ----- rtl/bfp_byte_unit.sv -----
`timescale 1ns / 1ps

module bfp_byte_unit import bfp_pkg::*; (
  input  byte_req_t req_i,
  output byte_res_t res_o
);

  logic [2:0]        lead;
  logic [3:0]        avail;
  logic [3:0]        nb;
  logic [3:0]        drop;
  logic [7:0]        nb_mask;
  logic [7:0]        field_bits;
  logic [7:0]        val_bits;
  logic [7:0]        keep_bits;
  logic [CntW-1:0]   shift;
  logic [ValueW+7:0] acc_wide;

  // Bits of the field that fall into this byte.
  always_comb begin
    lead    = req_i.first ? req_i.lead : 3'd0;
    avail   = 4'd8 - {1'b0, lead};
    nb      = (req_i.rem < {4'd0, avail}) ? req_i.rem[3:0] : avail;
    drop    = avail - nb;
    nb_mask = 8'hFF >> (4'd8 - nb);
    shift   = req_i.rem - {4'd0, nb};
  end

  // Read side: append the field bits and strip anything above the value width.
  always_comb begin
    field_bits  = (req_i.rdata & (8'hFF >> lead)) >> drop;
    acc_wide    = ({8'd0, req_i.acc} << nb) | {{ValueW{1'b0}}, field_bits};
    res_o.dirty = |(acc_wide & ~{8'd0, req_i.kmask});
    res_o.acc   = acc_wide[ValueW-1:0] & req_i.kmask;
  end

  // Write side: earlier bits of the first byte stay, later bits are cleared.
  always_comb begin
    val_bits    = 8'(req_i.wv >> shift) & nb_mask;
    keep_bits   = req_i.first ? (req_i.rdata & ~(8'hFF >> lead)) : 8'h00;
    res_o.wbyte = keep_bits | (val_bits << drop);
    res_o.rem   = shift;
  end

endmodule
